FILE: rtl/echo_pulse_range_kalman_unit_defines.svh
// Assertion helpers used by the top-level unit to check behaviour.
`ifndef ECHO_PULSE_RANGE_KALMAN_UNIT_DEFINES_SVH
`define ECHO_PULSE_RANGE_KALMAN_UNIT_DEFINES_SVH

// Check that a property holds on every rising clock edge outside reset.
`define EPRK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs outside reset.
`define EPRK_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/epr_kal_pkg.sv
package epr_kal_pkg;

  // Field and datapath widths, divider steps and queue depth
  localparam int unsigned OverflowBitsDef = 6;
  localparam int unsigned CountW          = 16;
  localparam int unsigned DistW           = 17;
  localparam int unsigned NoiseW          = 24;
  localparam int unsigned ScaleW          = 24;
  localparam int unsigned CovW            = 32;
  localparam int unsigned EstW            = 33;
  localparam int unsigned FracW           = 24;
  localparam int unsigned GainW           = 25;
  localparam int unsigned EstFracW        = 16;
  localparam int unsigned MulAW           = 33;
  localparam int unsigned MulBW           = 25;
  localparam int unsigned ProdW           = MulAW + MulBW;
  localparam int unsigned DivSteps        = 25;
  localparam int unsigned QueueDepth      = 2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgProcessNoise = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMeasureNoise = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgInitCov      = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgCmPerTick    = CfgIdxW'(3);

  // Register reset values
  localparam logic [NoiseW-1:0] ProcessNoiseRst = NoiseW'(13422);
  localparam logic [NoiseW-1:0] MeasureNoiseRst = NoiseW'(33554);
  localparam logic [CovW-1:0]   InitCovRst      = CovW'(167772160);
  localparam logic [ScaleW-1:0] CmPerTickRst    = ScaleW'(285213);

  // Fixed constants
  localparam logic [CountW-1:0] HeldSat = {CountW{1'b1}};
  localparam logic [DistW-1:0]  DistMax = {DistW{1'b1}};
  localparam logic [GainW-1:0]  OneQ24  = GainW'(1) << FracW;

  // Per-word status that rides with each job to the result
  typedef struct packed {
    logic new_sample;
    logic counter_clear;
    logic edge_polarity;
    logic capture_done;
  } res_flags_t;

  localparam int unsigned JobWDef = $bits(res_flags_t) + OverflowBitsDef + CountW;

endpackage

FILE: rtl/epr_kal_front.sv
module epr_kal_front #(
  parameter int unsigned OverflowBits = epr_kal_pkg::OverflowBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_push_i,
  output logic                                 in_full_o,
  input  logic                                 req_type_i,
  input  logic                                 update_flag_i,
  input  logic                                 capture_flag_i,
  input  logic [epr_kal_pkg::CountW-1:0]       capture_count_i,
  output logic                                 job_push_o,
  input  logic                                 job_full_i,
  output epr_kal_pkg::res_flags_t              job_flags_o,
  output logic [OverflowBits+epr_kal_pkg::CountW-1:0] job_width_o
);

  logic                            done_q, done_d;
  logic                            high_q, high_d;
  logic [OverflowBits-1:0]         ovf_q, ovf_d;
  logic [epr_kal_pkg::CountW-1:0]  held_q, held_d;
  logic                            pol_q, pol_d;
  logic                            fresh, clear;
  logic                            accept;

  assign accept    = in_push_i && !job_full_i;
  assign in_full_o = job_full_i;

  // Run the capture machine on the incoming word
  always_comb begin
    done_d = done_q;
    high_d = high_q;
    ovf_d  = ovf_q;
    held_d = held_q;
    pol_d  = pol_q;
    fresh  = 1'b0;
    clear  = 1'b0;
    if (req_type_i) begin
      if (done_q) begin
        fresh  = 1'b1;
        done_d = 1'b0;
        high_d = 1'b0;
        ovf_d  = '0;
      end
    end else if (!done_q) begin
      if (update_flag_i && high_q) begin
        if (ovf_q == {OverflowBits{1'b1}}) begin
          done_d = 1'b1;
          held_d = epr_kal_pkg::HeldSat;
        end else begin
          ovf_d = ovf_q + OverflowBits'(1);
        end
      end
      if (capture_flag_i) begin
        if (high_q) begin
          done_d = 1'b1;
          held_d = capture_count_i;
          pol_d  = 1'b0;
        end else begin
          ovf_d  = '0;
          held_d = '0;
          high_d = 1'b1;
          pol_d  = 1'b1;
          clear  = 1'b1;
        end
      end
    end
  end

  // Hand the classified word to the back end
  assign job_push_o                = accept;
  assign job_flags_o.new_sample    = fresh;
  assign job_flags_o.counter_clear = clear;
  assign job_flags_o.edge_polarity = pol_d;
  assign job_flags_o.capture_done  = done_d;
  assign job_width_o               = {ovf_q, held_q};

  // Advance capture state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      high_q <= 1'b0;
      ovf_q  <= '0;
      held_q <= '0;
      pol_q  <= 1'b0;
    end else if (accept) begin
      done_q <= done_d;
      high_q <= high_d;
      ovf_q  <= ovf_d;
      held_q <= held_d;
      pol_q  <= pol_d;
    end
  end

endmodule

FILE: rtl/epr_kal_fifo.sv
module epr_kal_fifo #(
  parameter int unsigned DataW = epr_kal_pkg::JobWDef,
  parameter int unsigned Depth = epr_kal_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [DataW-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: rtl/epr_kal_back.sv
module epr_kal_back #(
  parameter int unsigned OverflowBits = epr_kal_pkg::OverflowBitsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        job_empty_i,
  output logic                                        job_pop_o,
  input  epr_kal_pkg::res_flags_t                     job_flags_i,
  input  logic [OverflowBits+epr_kal_pkg::CountW-1:0] job_width_i,
  input  logic                                        cfg_valid_i,
  input  logic [epr_kal_pkg::CfgIdxW-1:0]             cfg_index_i,
  input  logic [epr_kal_pkg::CfgDataW-1:0]            cfg_data_i,
  input  logic                                        out_pop_i,
  output logic                                        out_empty_o,
  output logic [epr_kal_pkg::DistW-1:0]               out_dist_o,
  output epr_kal_pkg::res_flags_t                     out_flags_o
);

  localparam int unsigned WidthW = OverflowBits + epr_kal_pkg::CountW;
  localparam int unsigned StepW  = $clog2(epr_kal_pkg::DivSteps);
  localparam int unsigned RemW   = epr_kal_pkg::CovW + 2;
  localparam int unsigned DenW   = epr_kal_pkg::CovW + 1;
  localparam int unsigned SumW   = epr_kal_pkg::ProdW + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ZMUL,
    ST_ZSAT,
    ST_DIV,
    ST_KFIX,
    ST_EMUL,
    ST_ZK,
    ST_EUPD,
    ST_PUPD,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration and filter state
  logic [epr_kal_pkg::NoiseW-1:0]  pn_q, mn_q;
  logic [epr_kal_pkg::ScaleW-1:0]  cm_q;
  logic [epr_kal_pkg::CovW-1:0]    cov_q;
  logic [epr_kal_pkg::EstW-1:0]    est_q;
  logic [epr_kal_pkg::DistW-1:0]   dist_q;
  logic [StepW-1:0]                step_q;

  // Output register
  logic                            out_valid_q;
  logic [epr_kal_pkg::DistW-1:0]   out_dist_q;
  epr_kal_pkg::res_flags_t         out_flags_q;

  // Datapath scratch
  logic [WidthW-1:0]               width_q;
  epr_kal_pkg::res_flags_t         flags_q;
  logic [epr_kal_pkg::CovW-1:0]    p_q;
  logic [DenW-1:0]                 den_q;
  logic [RemW-1:0]                 rem_q;
  logic [epr_kal_pkg::GainW-1:0]   quo_q;
  logic [epr_kal_pkg::DistW-1:0]   z_q;
  logic [epr_kal_pkg::GainW-1:0]   k_q, omk_q;
  logic [epr_kal_pkg::ProdW-1:0]   prod_q, acc_q;

  logic                            out_free;
  logic                            take_pass, take_kal;
  logic [DenW-1:0]                 p_sum;
  logic [epr_kal_pkg::CovW-1:0]    p_sat;
  logic                            div_ge;
  logic [RemW-1:0]                 div_sel;
  logic [epr_kal_pkg::GainW-1:0]   k_val;
  logic [SumW-1:0]                 est_sum;
  logic [epr_kal_pkg::MulAW-1:0]   mul_a;
  logic [epr_kal_pkg::MulBW-1:0]   mul_b;

  assign out_free    = !out_valid_q || out_pop_i;
  assign take_kal    = (state_q == ST_IDLE) && !job_empty_i && job_flags_i.new_sample;
  assign take_pass   = (state_q == ST_IDLE) && !job_empty_i && !job_flags_i.new_sample
                       && out_free;
  assign job_pop_o   = take_kal || take_pass;
  assign out_empty_o = !out_valid_q;
  assign out_dist_o  = out_dist_q;
  assign out_flags_o = out_flags_q;

  // Predicted covariance, saturated
  assign p_sum = {1'b0, cov_q} + DenW'(pn_q);
  assign p_sat = p_sum[DenW-1] ? {epr_kal_pkg::CovW{1'b1}} : p_sum[epr_kal_pkg::CovW-1:0];

  // One restoring division step
  assign div_ge  = rem_q >= RemW'(den_q);
  assign div_sel = div_ge ? (rem_q - RemW'(den_q)) : rem_q;

  // Gain, clamped to one and forced to zero on a zero denominator
  always_comb begin
    if (den_q == '0) begin
      k_val = '0;
    end else if (quo_q > epr_kal_pkg::OneQ24) begin
      k_val = epr_kal_pkg::OneQ24;
    end else begin
      k_val = quo_q;
    end
  end

  // New estimate from the two partial products
  assign est_sum = SumW'(acc_q) + (SumW'(prod_q) << epr_kal_pkg::EstFracW);

  // Select operands of the shared multiplier
  always_comb begin
    case (state_q)
      ST_ZMUL: begin
        mul_a = epr_kal_pkg::MulAW'(width_q);
        mul_b = epr_kal_pkg::MulBW'(cm_q);
      end
      ST_EMUL: begin
        mul_a = est_q;
        mul_b = omk_q;
      end
      ST_ZK: begin
        mul_a = epr_kal_pkg::MulAW'(z_q);
        mul_b = k_q;
      end
      ST_EUPD: begin
        mul_a = epr_kal_pkg::MulAW'(p_q);
        mul_b = omk_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer, filter state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pn_q        <= epr_kal_pkg::ProcessNoiseRst;
      mn_q        <= epr_kal_pkg::MeasureNoiseRst;
      cm_q        <= epr_kal_pkg::CmPerTickRst;
      cov_q       <= epr_kal_pkg::InitCovRst;
      est_q       <= '0;
      dist_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_dist_q  <= '0;
      out_flags_q <= '0;
    end else begin
      if (out_pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          epr_kal_pkg::CfgProcessNoise: pn_q <= cfg_data_i[epr_kal_pkg::NoiseW-1:0];
          epr_kal_pkg::CfgMeasureNoise: mn_q <= cfg_data_i[epr_kal_pkg::NoiseW-1:0];
          epr_kal_pkg::CfgInitCov: begin
            cov_q <= cfg_data_i[epr_kal_pkg::CovW-1:0];
          end
          epr_kal_pkg::CfgCmPerTick: cm_q <= cfg_data_i[epr_kal_pkg::ScaleW-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take_kal) begin
            state_q <= ST_ZMUL;
          end else if (take_pass) begin
            out_valid_q <= 1'b1;
            out_dist_q  <= dist_q;
            out_flags_q <= job_flags_i;
          end
        end
        ST_ZMUL: state_q <= ST_ZSAT;
        ST_ZSAT: begin
          step_q  <= StepW'(epr_kal_pkg::DivSteps - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (step_q == '0) begin
            state_q <= ST_KFIX;
          end else begin
            step_q <= step_q - StepW'(1);
          end
        end
        ST_KFIX: state_q <= ST_EMUL;
        ST_EMUL: state_q <= ST_ZK;
        ST_ZK:   state_q <= ST_EUPD;
        ST_EUPD: begin
          est_q   <= est_sum[epr_kal_pkg::FracW +: epr_kal_pkg::EstW];
          state_q <= ST_PUPD;
        end
        ST_PUPD: begin
          cov_q   <= prod_q[epr_kal_pkg::FracW +: epr_kal_pkg::CovW];
          dist_q  <= est_q[epr_kal_pkg::EstFracW +: epr_kal_pkg::DistW];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_dist_q  <= dist_q;
            out_flags_q <= flags_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the filter step
  always_ff @(posedge clk_i) begin
    if (take_kal) begin
      width_q <= job_width_i;
      flags_q <= job_flags_i;
      p_q     <= p_sat;
    end
    case (state_q)
      ST_ZMUL: begin
        prod_q <= mul_a * mul_b;
        den_q  <= {1'b0, p_q} + DenW'(mn_q);
        rem_q  <= RemW'(p_q);
        quo_q  <= '0;
      end
      ST_ZSAT: begin
        if (prod_q[epr_kal_pkg::ProdW-1:epr_kal_pkg::FracW+epr_kal_pkg::DistW] != '0) begin
          z_q <= epr_kal_pkg::DistMax;
        end else begin
          z_q <= prod_q[epr_kal_pkg::FracW +: epr_kal_pkg::DistW];
        end
      end
      ST_DIV: begin
        quo_q <= {quo_q[epr_kal_pkg::GainW-2:0], div_ge};
        rem_q <= {div_sel[RemW-2:0], 1'b0};
      end
      ST_KFIX: begin
        k_q   <= k_val;
        omk_q <= epr_kal_pkg::OneQ24 - k_val;
      end
      ST_EMUL: prod_q <= mul_a * mul_b;
      ST_ZK: begin
        acc_q  <= prod_q;
        prod_q <= mul_a * mul_b;
      end
      ST_EUPD: prod_q <= mul_a * mul_b;
      default: ;
    endcase
  end

endmodule

FILE: rtl/echo_pulse_range_kalman_unit.sv
// Echo pulse range unit with a scalar Kalman smoother. Timer events (req_type_i 0)
// drive a pulse width capture machine; a distance read (req_type_i 1) that finds a
// finished capture converts the width to centimetres, runs one fixed-point Kalman
// step and re-arms capture, and every word pushed yields exactly one result word.
// Timer events and reads without a finished capture pass the front end and the job
// queue into the result register once the back end is idle and the result register
// is free. A read that consumes a capture occupies the back end for one pass of the
// shared 33x25 multiplier for the scale, the bit-serial restoring divider for the
// gain, three more multiplier passes for the estimate and covariance, and sequencing
// states. A two-word queue between front and back lets the front accept up to two
// more words while that step runs; after that full stays high until the back end
// pops the next word. Configuration writes are always ready and must be issued only
// while the unit is idle; writing initial_covariance also reloads the covariance.
`include "echo_pulse_range_kalman_unit_defines.svh"

module echo_pulse_range_kalman_unit #(
  parameter int unsigned OverflowBits = epr_kal_pkg::OverflowBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              req_type_i,
  input  logic                              update_flag_i,
  input  logic                              capture_flag_i,
  input  logic [epr_kal_pkg::CountW-1:0]    capture_count_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [epr_kal_pkg::DistW-1:0]     distance_cm_o,
  output logic                              new_sample_o,
  output logic                              counter_clear_o,
  output logic                              edge_polarity_o,
  output logic                              capture_done_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [epr_kal_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [epr_kal_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned WidthW = OverflowBits + epr_kal_pkg::CountW;
  localparam int unsigned FlagW  = $bits(epr_kal_pkg::res_flags_t);
  localparam int unsigned JobW   = FlagW + WidthW;

  logic                    job_push, job_full, job_pop, job_empty;
  epr_kal_pkg::res_flags_t fr_flags, bk_flags, res_flags;
  logic [WidthW-1:0]       fr_width, bk_width;
  logic [JobW-1:0]         job_wdata, job_rdata;

  assign cfg_ready_o = 1'b1;

  // Classify words and run the capture machine
  epr_kal_front #(
    .OverflowBits(OverflowBits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_push_i      (push),
    .in_full_o      (full),
    .req_type_i     (req_type_i),
    .update_flag_i  (update_flag_i),
    .capture_flag_i (capture_flag_i),
    .capture_count_i(capture_count_i),
    .job_push_o     (job_push),
    .job_full_i     (job_full),
    .job_flags_o    (fr_flags),
    .job_width_o    (fr_width)
  );

  assign job_wdata = {fr_flags, fr_width};

  // Buffer jobs between front and back
  epr_kal_fifo #(
    .DataW(JobW),
    .Depth(epr_kal_pkg::QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_wdata),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (job_rdata),
    .empty_o(job_empty)
  );

  assign bk_flags = job_rdata[JobW-1 -: FlagW];
  assign bk_width = job_rdata[WidthW-1:0];

  // Carry out filter steps and hold results
  epr_kal_back #(
    .OverflowBits(OverflowBits)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(job_empty),
    .job_pop_o  (job_pop),
    .job_flags_i(bk_flags),
    .job_width_i(bk_width),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_pop_i  (pop),
    .out_empty_o(empty),
    .out_dist_o (distance_cm_o),
    .out_flags_o(res_flags)
  );

  assign new_sample_o    = res_flags.new_sample;
  assign counter_clear_o = res_flags.counter_clear;
  assign edge_polarity_o = res_flags.edge_polarity;
  assign capture_done_o  = res_flags.capture_done;

  // Checks
  `EPRK_ASSERT_NEVER(a_fresh_and_clear, !empty && new_sample_o && counter_clear_o, "read result also clears counter")
  `EPRK_ASSERT(a_fresh_not_done, (!empty && new_sample_o) |-> !capture_done_o, "consumed capture still marked done")
  `EPRK_ASSERT(a_clear_arms_fall, (!empty && counter_clear_o) |-> edge_polarity_o, "counter clear without falling edge armed")
  `EPRK_ASSERT_NEVER(a_job_overrun, job_push && job_full, "job pushed into full queue")

endmodule
